>>> rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_ALL   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_READ_ALL
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DUMP
    } state_t;

endpackage

>>> rtl/cdq_front.sv
module cdq_front (
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  logic [cdq_pkg::KIND_W-1:0]              kind,
    input  logic signed [cdq_pkg::WORD_W-1:0]       value,
    input  cdq_pkg::q_status_t                      q_status,
    output logic                                    push,
    output cdq_pkg::cmd_t                           push_cmd
);
    import cdq_pkg::*;

    logic kind_ok;

    always_comb
    begin
        kind_ok = kind inside {[KIND_PUSH_FRONT:KIND_READ_ALL]};
        push_cmd.value = value;
        case (kind)
            KIND_PUSH_FRONT: push_cmd.op = OP_PUSH_FRONT;
            KIND_PUSH_BACK:  push_cmd.op = OP_PUSH_BACK;
            KIND_POP_FRONT:  push_cmd.op = OP_POP_FRONT;
            KIND_POP_BACK:   push_cmd.op = OP_POP_BACK;
            default:         push_cmd.op = OP_READ_ALL;
        endcase
    end

    // undefined kinds are taken and dropped
    assign req_stall = q_status.full;
    assign push      = req_valid && !q_status.full && kind_ok;

endmodule

>>> rtl/cdq_queue.sv
module cdq_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cdq_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output cdq_pkg::cmd_t      pop_cmd,
    output cdq_pkg::q_status_t q_status
);
    import cdq_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd        = entry_reg[rd_ptr_reg];
    assign q_status.full  = fill_reg[1];
    assign q_status.empty = (fill_reg == 2'd0);

endmodule

>>> rtl/cdq_back.sv
module cdq_back #(
    parameter int CAPACITY = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cdq_pkg::q_status_t                      q_status,
    input  cdq_pkg::cmd_t                           pop_cmd,
    output logic                                    pop,
    output logic                                    rsp_valid,
    input  logic                                    rsp_stall,
    output logic signed [cdq_pkg::WORD_W-1:0]       item,
    output logic [cdq_pkg::STATUS_W-1:0]            status,
    output logic                                    last
);
    import cdq_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] TOP_SLOT  = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [PW:0]   CAP_WIDE  = (PW + 1)'(CAPACITY);

    logic signed [WORD_W-1:0] mem [CAPACITY];

    state_t                   state_reg, state_next;
    logic [PW-1:0]            front_reg, front_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [PW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]            remain_reg, remain_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic signed [WORD_W-1:0] item_reg, item_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     last_reg, last_next;
    logic signed [WORD_W-1:0] rd_data_reg;

    logic                     out_free;
    logic                     mem_we;
    logic [PW-1:0]            wr_addr;
    logic                     rd_en;
    logic [PW-1:0]            rd_addr;

    function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                           input logic [CW-1:0] offset);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, offset[PW-1:0]};
        if (sum >= CAP_WIDE)
        begin
            sum = sum - CAP_WIDE;
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == TOP_SLOT) ? '0 : p + PW'(1);
    endfunction

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty && out_free)
                begin
                    if ((pop_cmd.op == OP_POP_FRONT || pop_cmd.op == OP_POP_BACK)
                        && count_reg != '0)
                    begin
                        state_next = ST_READ;
                    end
                    else if (pop_cmd.op == OP_READ_ALL && count_reg != '0)
                    begin
                        state_next = ST_DUMP;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_free && remain_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        item_next      = item_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = front_reg;
        rd_en          = 1'b0;
        rd_addr        = front_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty && out_free)
                begin
                    pop = 1'b1;
                    case (pop_cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            item_next      = '0;
                            last_next      = 1'b1;
                            if (count_reg == CAP_COUNT)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                status_next = STATUS_OK;
                                mem_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                if (pop_cmd.op == OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? TOP_SLOT
                                                                   : front_reg - PW'(1);
                                    wr_addr    = front_next;
                                end
                                else
                                begin
                                    wr_addr = slot(front_reg, count_reg);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                item_next      = '0;
                                status_next    = STATUS_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (pop_cmd.op == OP_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = next_slot(front_reg);
                                end
                                else
                                begin
                                    rd_addr = slot(front_reg, count_reg - CW'(1));
                                end
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                item_next      = '0;
                                status_next    = STATUS_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg;
                                rd_ptr_next = next_slot(front_reg);
                                remain_next = count_reg;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = rd_data_reg;
                    status_next    = STATUS_OK;
                    last_next      = 1'b1;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = rd_data_reg;
                    status_next    = STATUS_OK;
                    last_next      = (remain_reg == CW'(1));
                    if (remain_reg != CW'(1))
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = rd_ptr_reg;
                        rd_ptr_next = next_slot(rd_ptr_reg);
                        remain_next = remain_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= pop_cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign item      = item_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

>>> rtl/circular_list_deque_unit.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | kind, value
// rsp     | out       | rsp_valid, rsp_stall | item, status, last
//
// Words pass through a two-entry command queue; the back end takes one when idle.
// Push, or any error result: goes straight to the result register. Pop: store read,
// then result. Read-out of N elements: one store read per element.
// Reset clears pointers, count and the queue; the element store needs no clearing.
// req_stall is raised only while the command queue is full; rsp_stall holds the
// result register and so backs up the queue.
module circular_list_deque_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  logic [cdq_pkg::KIND_W-1:0]              kind,
    input  logic signed [cdq_pkg::WORD_W-1:0]       value,
    output logic                                    rsp_valid,
    input  logic                                    rsp_stall,
    output logic signed [cdq_pkg::WORD_W-1:0]       item,
    output logic [cdq_pkg::STATUS_W-1:0]            status,
    output logic                                    last
);
    import cdq_pkg::*;

    q_status_t q_status;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      pop_cmd;

    cdq_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .value     (value),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    cdq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    cdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .item      (item),
        .status    (status),
        .last      (last)
    );

endmodule

>>> rtl/cdq_checker.sv
module cdq_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    req_valid,
    input logic                                    req_stall,
    input logic [cdq_pkg::KIND_W-1:0]              kind,
    input logic signed [cdq_pkg::WORD_W-1:0]       value,
    input logic                                    rsp_valid,
    input logic                                    rsp_stall,
    input logic signed [cdq_pkg::WORD_W-1:0]       item,
    input logic [cdq_pkg::STATUS_W-1:0]            status,
    input logic                                    last
);
    import cdq_pkg::*;

    // stalled request word is held
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(kind) && $stable(value))
        else $error("request word changed while stalled");

    // stalled word is held
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(item) && $stable(status)
                                   && $stable(last))
        else $error("result word changed while stalled");

    // error results carry no element and end their word sequence
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |-> item == '0 && last)
        else $error("error result with non-zero item or without last");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == STATUS_OK || status == STATUS_EMPTY
                      || status == STATUS_FULL)
        else $error("undefined status code");

    // a word is never shown in the cycle after reset is released
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result word straight out of reset");

endmodule

bind circular_list_deque_unit cdq_checker u_cdq_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    import cdq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = DEPTH + 16;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct {
        logic signed [WORD_W-1:0] item;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } deque_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic [KIND_W-1:0]          kind = '0;
    logic signed [WORD_W-1:0]   value = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic signed [WORD_W-1:0]   item;
    logic [STATUS_W-1:0]        status;
    logic                       last;

    // shadow of the deque
    logic signed [WORD_W-1:0]   store_mem [DEPTH];
    int                         head_idx = 0;
    int                         fill_count = 0;
    deque_reply_t               pending_replies [$];

    int err_count = 0;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;

    circular_list_deque_unit #(.CAPACITY(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .item      (item),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic queue_reply(input logic signed [WORD_W-1:0] it,
                               input logic [STATUS_W-1:0] st, input logic lst);
        deque_reply_t r;
        r.item   = it;
        r.status = st;
        r.last   = lst;
        pending_replies.push_back(r);
    endtask

    // expected replies for one accepted word
    task automatic apply_deque_op(input logic [KIND_W-1:0] k,
                                  input logic signed [WORD_W-1:0] v);
        int n;
        case (k)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (fill_count == DEPTH)
                    queue_reply('0, STATUS_FULL, 1'b1);
                else
                begin
                    if (k == KIND_PUSH_FRONT)
                    begin
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                        store_mem[head_idx] = v;
                    end
                    else
                        store_mem[(head_idx + fill_count) % DEPTH] = v;
                    fill_count++;
                    queue_reply('0, STATUS_OK, 1'b1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (fill_count == 0)
                    queue_reply('0, STATUS_EMPTY, 1'b1);
                else
                begin
                    if (k == KIND_POP_FRONT)
                    begin
                        queue_reply(store_mem[head_idx], STATUS_OK, 1'b1);
                        head_idx = (head_idx + 1) % DEPTH;
                    end
                    else
                        queue_reply(store_mem[(head_idx + fill_count - 1) % DEPTH],
                                    STATUS_OK, 1'b1);
                    fill_count--;
                end
            end
            KIND_READ_ALL:
            begin
                if (fill_count == 0)
                    queue_reply('0, STATUS_EMPTY, 1'b1);
                else
                    for (n = 0; n < fill_count; n++)
                        queue_reply(store_mem[(head_idx + n) % DEPTH], STATUS_OK,
                                    n == fill_count - 1);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        deque_reply_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                apply_deque_op(kind, value);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch($sformatf("unexpected word item %0d status %0d last %0d",
                                              item, status, last));
                else
                begin
                    want = pending_replies.pop_front();
                    if (item !== want.item)
                        report_mismatch($sformatf("item %0d, want %0d", item, want.item));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", status,
                                                  want.status));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", last, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (!req_valid && pending_replies.size() == 0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stall, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [WORD_W-1:0] v);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        kind      = k;
        value     = v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(KIND_POP_FRONT, 32'sd5);
        send_word(KIND_POP_BACK, -32'sd5);
        send_word(KIND_READ_ALL, '0);
        send_word(KIND_PUSH_FRONT, 32'sh7fffffff);
        send_word(KIND_PUSH_BACK, 32'sh80000000);
        send_word(KIND_PUSH_FRONT, '0);
        send_word(KIND_PUSH_BACK, -32'sd1);
        send_word(KIND_READ_ALL, -32'sd1);
        send_word(KIND_UNUSED_LO, 32'sh12345678);
        send_word(KIND_UNUSED_LO + 3'd1, -32'sd1);
        send_word(KIND_UNUSED_HI, 32'sh7fffffff);
        send_word(KIND_POP_FRONT, '0);
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_POP_FRONT, '0);
        send_word(KIND_READ_ALL, '0);
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_POP_BACK, '0);
        send_word(KIND_READ_ALL, '0);
        send_word(KIND_PUSH_BACK, 32'sd1);
        send_word(KIND_POP_FRONT, '0);
        wait_drained();
    endtask

    // fill to capacity from both ends, overflow, read back, drain
    task automatic test_full_store();
        int n;
        for (n = 0; n < DEPTH / 2; n++)
            send_word(KIND_PUSH_BACK, pick_value());
        while (fill_count < DEPTH || pending_replies.size() != 0)
        begin
            if (fill_count + pending_replies.size() < DEPTH)
                send_word(KIND_PUSH_FRONT, pick_value());
            else
            begin
                req_valid = 1'b0;
                @(negedge clk);
            end
        end
        send_word(KIND_PUSH_FRONT, pick_value());
        send_word(KIND_PUSH_BACK, pick_value());
        send_word(KIND_READ_ALL, '0);
        for (n = 0; n <= DEPTH; n++)
            send_word(n[0] ? KIND_POP_BACK : KIND_POP_FRONT, '0);
        send_word(KIND_READ_ALL, '0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int  n;
        int  r;
        bit  growing;
        logic [KIND_W-1:0] k;
        growing = 1'b1;
        n = 0;
        while (n < count)
        begin
            if (fill_count >= DEPTH - 1)
                growing = 1'b0;
            else if (fill_count <= 1 || $urandom_range(0, 99) < 4)
                growing = ($urandom_range(0, 3) != 0) ? 1'b1 : growing;
            r = $urandom_range(0, 99);
            if (r < 3)
                k = KIND_UNUSED_LO + 3'($urandom_range(0, 2));
            else if (r < 11)
                k = KIND_READ_ALL;
            else if (r < (growing ? 75 : 40))
                k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            else
                k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
            send_word(k, pick_value());
            if (k <= KIND_READ_ALL)
                n++;
        end
        req_valid = 1'b0;
    endtask

    // receiver holds off while the sender keeps going
    task automatic test_backpressure();
        int n;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_ask++;
        for (n = 0; n < 40; n++)
            send_word(n < 24 ? KIND_PUSH_BACK : KIND_POP_FRONT, pick_value());
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_store();
        test_backpressure();

        send_gap_pct = 0;
        stall_pct    = 0;
        test_random(100);
        send_gap_pct = 79;
        stall_pct    = 0;
        test_random(90);
        send_gap_pct = 0;
        stall_pct    = 79;
        test_random(90);
        send_gap_pct = 26;
        stall_pct    = 26;
        test_random(100);

        stall_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
